>>> design/lsbx_pkg.sv
package lsbx_pkg;

	localparam int CHAN_W          = 8;
	localparam int VALUE_W         = 21;
	localparam int LENGTH_BITS_DEF = 21;
	localparam int HDR_BITS        = 9;   // header bits carried by one pixel

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_MESSAGE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic              new_image;
	} pixel_t;

	typedef struct packed {
		logic               is_length;
		logic [VALUE_W-1:0] value;
		logic               last;
	} result_t;

endpackage

>>> design/lsbx_pix_if.sv
interface lsbx_pix_if;
	import lsbx_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] red;
	logic              new_image;

	modport source (output valid, output blue, output green, output red, output new_image,
		input ready);
	modport sink (input valid, input blue, input green, input red, input new_image,
		output ready);
endinterface

>>> design/lsbx_res_if.sv
interface lsbx_res_if;
	import lsbx_pkg::*;

	logic               valid;
	logic               ready;
	logic               is_length;
	logic [VALUE_W-1:0] value;
	logic               last;

	modport source (output valid, output is_length, output value, output last, input ready);
	modport sink (input valid, input is_length, input value, input last, output ready);
endinterface

>>> design/lsbx_in_stage.sv
module lsbx_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	lsbx_pix_if.sink        pixel,
	input  logic            advance,
	output logic            take,
	output lsbx_pkg::pixel_t pix
);
	import lsbx_pkg::*;

	logic   valid_s1;
	pixel_t data_s1;

	assign take        = valid_s1 && advance;
	assign pixel.ready = !valid_s1 || advance;
	assign pix         = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.ready && pixel.valid) begin
			data_s1 <= '{blue: pixel.blue, green: pixel.green, red: pixel.red,
				new_image: pixel.new_image};
		end
	end
endmodule

>>> design/lsbx_decode.sv
module lsbx_decode #(
	parameter int LENGTH_BITS = lsbx_pkg::LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  lsbx_pkg::pixel_t pix,
	output logic             res_valid,
	output lsbx_pkg::result_t res
);
	import lsbx_pkg::*;

	localparam int BPW  = $clog2(LENGTH_BITS);
	localparam int CMPW = (BPW > 4) ? BPW : 4;

	// cnt_q holds the length while it is assembled, then the bytes still owed
	phase_t                 phase_q, phase_d, ph;
	logic [BPW-1:0]         hbp_q, hbp_d;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d, cnt;
	logic [5:0]             byte_q, byte_d;
	logic [1:0]             mcnt_q, mcnt_d, mcnt;
	logic [CMPW-1:0]        bp_ext, shamt, drop;
	logic [HDR_BITS-1:0]    nine;
	logic [LENGTH_BITS-1:0] acc_n, left_n;

	always_comb begin
		// new_image restarts the header before this pixel is used
		ph     = pix.new_image ? PH_HEADER : phase_q;
		bp_ext = pix.new_image ? CMPW'(LENGTH_BITS - 1) : CMPW'(hbp_q);
		cnt    = pix.new_image ? '0 : cnt_q;
		mcnt   = pix.new_image ? 2'd0 : mcnt_q;

		nine   = {pix.blue[0], pix.blue[1], pix.blue[2],
			pix.green[0], pix.green[1], pix.green[2],
			pix.red[0], pix.red[1], pix.red[2]};
		shamt  = bp_ext + CMPW'(1);
		drop   = CMPW'(HDR_BITS - 1) - bp_ext;
		acc_n  = (bp_ext >= CMPW'(HDR_BITS))
			? ((cnt << HDR_BITS) | LENGTH_BITS'(nine))
			: ((cnt << shamt) | LENGTH_BITS'(nine >> drop));
		left_n = cnt - LENGTH_BITS'(1);

		phase_d   = ph;
		hbp_d     = BPW'(bp_ext);
		cnt_d     = cnt;
		byte_d    = byte_q;
		mcnt_d    = mcnt;
		res_valid = 1'b0;
		res       = '{is_length: 1'b0, value: '0, last: 1'b0};

		unique case (ph)
			PH_HEADER: begin
				cnt_d = acc_n;
				if (bp_ext >= CMPW'(HDR_BITS)) begin
					hbp_d = BPW'(bp_ext - CMPW'(HDR_BITS));
				end else begin
					// length complete; rest of the pixel is dropped
					res_valid = 1'b1;
					res       = '{is_length: 1'b1, value: VALUE_W'(acc_n),
						last: (acc_n == '0)};
					phase_d   = (acc_n == '0) ? PH_DONE : PH_MESSAGE;
					mcnt_d    = 2'd0;
				end
			end
			PH_MESSAGE: begin
				unique case (mcnt)
					2'd0: begin
						byte_d = {pix.blue[0], pix.green[0], pix.red[0], 3'b000};
						mcnt_d = 2'd1;
					end
					2'd1: begin
						byte_d = {byte_q[5:3], pix.blue[0], pix.green[0], pix.red[0]};
						mcnt_d = 2'd2;
					end
					default: begin
						// third pixel: red is skipped
						res_valid = 1'b1;
						res       = '{is_length: 1'b0,
							value: VALUE_W'({byte_q, pix.blue[0], pix.green[0]}),
							last: (left_n == '0)};
						cnt_d     = left_n;
						mcnt_d    = 2'd0;
						phase_d   = (left_n == '0) ? PH_DONE : PH_MESSAGE;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hbp_q   <= BPW'(LENGTH_BITS - 1);
			cnt_q   <= '0;
			mcnt_q  <= 2'd0;
		end else if (take) begin
			phase_q <= phase_d;
			hbp_q   <= hbp_d;
			cnt_q   <= cnt_d;
			mcnt_q  <= mcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= byte_d;
		end
	end
endmodule

>>> design/lsb_stego_message_extractor.sv
// channel | dir | payload                         | handshake
// pixel   | in  | blue, green, red, new_image     | valid/ready
// result  | out | is_length, value, last          | valid/ready
//
// One pixel per clock while the result port does not stall; a result reaches
// the port through the input register, then the result register.
// Per pixel: one short shift-merge into the length and one decrement.
// arst_n clears both stages and restarts decoding at the header.
// A stalled result holds the result register; the input register keeps
// taking pixels until it too is full, then pixel.ready drops.
module lsb_stego_message_extractor #(
	parameter int LENGTH_BITS = lsbx_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lsbx_pix_if.sink   pixel,
	lsbx_res_if.source result
);
	import lsbx_pkg::*;

	logic    advance;     // decode stage may move on this cycle
	logic    take;        // a pixel is decoded this cycle
	pixel_t  pix;
	logic    res_valid;
	result_t res;

	logic    out_valid_q;
	result_t out_q;

	// result register free, or being emptied now
	assign advance = !out_valid_q || result.ready;

	lsbx_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.advance (advance),
		.take    (take),
		.pix     (pix)
	);

	lsbx_decode #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.pix       (pix),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.is_length = out_q.is_length;
	assign result.value     = out_q.value;
	assign result.last      = out_q.last;

`ifndef SYNTHESIS
	// input side never blocks while the result register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> pixel.ready)
		else $error("pixel stalled with empty result register");

	// an empty message is signaled by a zero length marked last
	a_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_length && out_q.last) |-> (out_q.value == '0))
		else $error("last length result with nonzero value");

	// message bytes use only the low eight bits
	a_byte_width: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.is_length) |-> (out_q.value[VALUE_W-1:8] == '0))
		else $error("message byte wider than eight bits");
`endif
endmodule
